### rtl/hist_pkg.sv
// Shared package for the fixed-width histogram core.
// Holds field widths, command and register index codes, and reset values.
// Used by hist_div and fixed_width_histogram_core; depends on nothing.
package hist_pkg;

   localparam int NUM_COUNTERS_DEF = 64;

   localparam int SAMPLE_W    = 64;
   localparam int WORD_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int LAST_BIN_W  = 6;
   localparam int CSR_INDEX_W = 8;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 96;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_WIDTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_BIN  = 8'd1;

   localparam logic [WORD_W-1:0]     BIN_WIDTH_RST = 32'd1;
   localparam logic [LAST_BIN_W-1:0] LAST_BIN_RST  = 6'd62;

endpackage

### rtl/hist_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters; no reset on the array or read data.
// Depends on nothing.
module hist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hist_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by a
// 32-bit divisor, low 32 quotient bits returned. Uses hist_pkg.
// A zero divisor yields an all-ones quotient, as restoring division does.
module hist_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hist_pkg::SAMPLE_W-1:0] dividend,
   input  logic [hist_pkg::WORD_W-1:0]   divisor,
   output logic                         done,
   output logic [hist_pkg::WORD_W-1:0]   quotient
);
   import hist_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0] dq_ff, dq_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   dvs_ff, dvs_in;

   logic [WORD_W:0]     shifted;
   logic [WORD_W+1:0]   diff;

   // For a nonzero divisor the remainder stays below the divisor; the shifted
   // value fits 33 bits and the trial difference 34 bits with borrow.
   assign shifted = {rem_ff, dq_ff[SAMPLE_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WORD_W+1]) begin
            rem_in = diff[WORD_W-1:0];
            dq_in  = {dq_ff[SAMPLE_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            dq_in  = {dq_ff[SAMPLE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff[WORD_W-1:0];

endmodule

### rtl/fixed_width_histogram_core.sv
// Fixed-width histogram core with an overflow bin.
// Request beats (req_*) carry a command in req_tuser: add a sample or read a
// counter. Each request gives exactly one response beat (rsp_*) with the bin
// index, the counter value, an overflow flag in rsp_tuser and the largest bin
// seen so far. Configuration beats on csr_* set the bin width (index 0) and
// the last ordinary bin (index 1); csr_ready is always high.
// An add goes through the restoring divider, which produces one quotient
// bit per cycle; then the counter RAM does a read, an increment and a write.
// A read goes straight to the counter RAM lookup, with no divide.
// Only one request is in flight; req_tready is high only while idle, so a
// new request is not taken until the last one has gone to the output register.
// After reset the counter RAM is cleared one entry per cycle, every entry in
// turn, while no request is taken. The response sits in an output
// register, so a stalled receiver does not stop the next request from being
// taken; that request waits for the register to empty before it finishes.
// Dependencies: hist_pkg, hist_div, hist_ram.
module fixed_width_histogram_core #(
   parameter int NUM_COUNTERS = hist_pkg::NUM_COUNTERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request: tdata = sample[63:0], read_index[69:64], zero pad.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hist_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Request tuser: cmd.
   input  logic                            req_tuser,
   // Response: tdata = bin_index[31:0], count[63:32], max_seen[95:64].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hist_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Response tuser: overflowed.
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hist_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hist_pkg::WORD_W-1:0]      csr_data
);
   import hist_pkg::*;

   localparam int CW = $clog2(NUM_COUNTERS);
   localparam logic [WORD_W-1:0] LAST_CAP  = WORD_W'(NUM_COUNTERS - 2);
   localparam logic [WORD_W-1:0] DEPTH_W   = WORD_W'(NUM_COUNTERS);
   localparam logic [CW-1:0]     ADDR_LAST = CW'(NUM_COUNTERS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_SEND   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         clr_ff, clr_in;
   logic [WORD_W-1:0]     bin_width_ff, bin_width_in;
   logic [LAST_BIN_W-1:0] last_bin_ff, last_bin_in;
   logic [WORD_W-1:0]     largest_ff, largest_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  cmd_ff, cmd_in;
   logic [INDEX_W-1:0]    read_index_ff, read_index_in;
   logic [WORD_W-1:0]     bin_ff, bin_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  ovf_ff, ovf_in;
   logic                  in_range_ff, in_range_in;
   logic [WORD_W-1:0]     count_ff, count_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  req_fire;
   logic                  div_start;
   logic                  div_done;
   logic [WORD_W-1:0]     div_quot;

   logic [WORD_W-1:0]     eff_last;
   logic                  in_bin;
   logic [WORD_W-1:0]     ridx_ext;
   logic [CW-1:0]         lookup_addr;

   logic                  ram_wr_en;
   logic [CW-1:0]         ram_wr_addr;
   logic [WORD_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [WORD_W-1:0]     incremented;
   logic                  rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign div_start  = req_fire && (req_tuser == CMD_ADD);
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // The last ordinary bin saturates so the overflow counter always exists.
   assign eff_last = (WORD_W'(last_bin_ff) > LAST_CAP) ? LAST_CAP
                                                       : WORD_W'(last_bin_ff);
   assign in_bin   = (bin_ff <= eff_last);
   assign ridx_ext = WORD_W'(read_index_ff);

   always_comb begin
      if (cmd_ff == CMD_ADD) begin
         lookup_addr = in_bin ? bin_ff[CW-1:0] : (eff_last[CW-1:0] + CW'(1));
      end else begin
         lookup_addr = ridx_ext[CW-1:0];
      end
   end

   assign incremented = ram_rd_data + WORD_W'(1);
   assign ram_rd_en   = (state_ff == ST_LOOKUP);
   assign ram_wr_en   = (state_ff == ST_CLEAR) ||
                        ((state_ff == ST_WRITE) && (cmd_ff == CMD_ADD));
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : incremented;

   hist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[SAMPLE_W-1:0]),
      .divisor  (bin_width_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   hist_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_COUNTERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (lookup_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      bin_width_in = bin_width_ff;
      last_bin_in  = last_bin_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIN_WIDTH: bin_width_in = csr_data;
            CSR_LAST_BIN:  last_bin_in  = csr_data[LAST_BIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      largest_in    = largest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd_in        = cmd_ff;
      read_index_in = read_index_ff;
      bin_in        = bin_ff;
      addr_in       = addr_ff;
      ovf_in        = ovf_ff;
      in_range_in   = in_range_ff;
      count_in      = count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            if (clr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_tuser;
               read_index_in = req_tdata[SAMPLE_W +: INDEX_W];
               bin_in        = WORD_W'(req_tdata[SAMPLE_W +: INDEX_W]);
               state_in      = (req_tuser == CMD_ADD) ? ST_DIV : ST_LOOKUP;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               bin_in   = div_quot;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            addr_in     = lookup_addr;
            ovf_in      = (cmd_ff == CMD_ADD) && !in_bin;
            in_range_in = (ridx_ext < DEPTH_W);
            state_in    = ST_WRITE;
         end
         ST_WRITE: begin
            if (cmd_ff == CMD_ADD) begin
               count_in = incremented;
               if (bin_ff > largest_ff) begin
                  largest_in = bin_ff;
               end
            end else begin
               count_in = in_range_ff ? ram_rd_data : '0;
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {largest_ff, count_ff, bin_ff};
               rsp_user_in  = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bin_width_ff <= BIN_WIDTH_RST;
         last_bin_ff  <= LAST_BIN_RST;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bin_width_ff <= bin_width_in;
         last_bin_ff  <= last_bin_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      read_index_ff <= read_index_in;
      bin_ff        <= bin_in;
      addr_ff       <= addr_in;
      ovf_ff        <= ovf_in;
      in_range_ff   <= in_range_in;
      count_ff      <= count_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
